// ===== design/cbsg_pkg.sv =====
// Shared types and constants of the cubic B-spline segment generator.
package cbsg_pkg;

    // Width and reset value of the steps_log2 configuration register.
    localparam int STEPS_W = 3;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 3'd6;

    // Number of control points held in the window.
    localparam logic [1:0] WINDOW_FULL = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_INIT,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               store;        // write the input point into the window
        logic [1:0]         store_idx;    // window slot for a store
        logic               load;         // latch the newest point of a span
        logic               coef;         // compute polynomial coefficients, shift window
        logic               init;         // set up the forward differences
        logic               issue;        // send one curve sum into the scaler
        logic               issue_first;  // the issued sum is at u = 0
        logic               issue_last;   // the issued sum is at u = 1
        logic [STEPS_W-1:0] steps;        // effective steps_log2 of this span
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic advance;  // pipeline moves this cycle
        logic busy;     // scaler stages still hold curve points
    } status_t;

endpackage

// ===== design/cbsg_scale.sv =====
// Scaler lane: divides a curve sum by 6*2^(3s), truncating toward zero.
module cbsg_scale #(
    parameter int COORD_BITS     = 16,
    parameter int MAX_STEPS_LOG2 = 6
) (
    input  logic                                     aclk,
    input  logic                                     en,
    input  logic [cbsg_pkg::STEPS_W-1:0]             steps,
    input  logic signed [COORD_BITS+3*MAX_STEPS_LOG2+6:0] sum_in,
    output logic signed [COORD_BITS-1:0]             q_out
);

    localparam int SW = COORD_BITS + 3 * MAX_STEPS_LOG2 + 7;
    localparam int UW = COORD_BITS + 1;
    localparam int PW = 2 * UW + 1;
    localparam int RW = UW + 2;
    // Reciprocal of three, scaled by 2^(UW+2) and rounded down.
    localparam logic [UW:0] RECIP = (UW + 1)'((64'd1 << (UW + 2)) / 64'd3);

    logic [4:0]    shift_amt;
    logic [SW-1:0] mag;
    logic          neg1_reg;
    logic [UW-1:0] u1_reg;
    logic          neg2_reg;
    logic [UW-1:0] u2_reg;
    logic [PW-1:0] prod_reg;
    logic [UW-1:0] q_est;
    logic [RW-1:0] rem;
    logic [UW-1:0] q_mag;
    logic [UW-1:0] q_sgn;

    // Shift by 3s for the power of two and one more for the factor two of six.
    assign shift_amt = {1'b0, steps, 1'b0} + {2'b00, steps} + 5'd1;
    assign mag = sum_in[SW-1] ? (SW'(0) - SW'(sum_in)) : SW'(sum_in);

    // Stage one takes the magnitude apart from the sign; stage two
    // multiplies by the reciprocal of three.
    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= sum_in[SW-1];
            u1_reg   <= UW'(mag >> shift_amt);
            neg2_reg <= neg1_reg;
            u2_reg   <= u1_reg;
            prod_reg <= PW'(u1_reg) * PW'(RECIP);
        end
    end

    // The estimate is low by at most one; one compare corrects it.
    always_comb begin
        q_est = UW'(prod_reg >> (UW + 2));
        rem   = RW'(u2_reg) - (RW'(q_est) << 1) - RW'(q_est);
        q_mag = (rem >= RW'(3)) ? (q_est + UW'(1)) : q_est;
        q_sgn = neg2_reg ? (UW'(0) - q_mag) : q_mag;
    end

    assign q_out = $signed(q_sgn[COORD_BITS-1:0]);

endmodule

// ===== design/cbsg_dp.sv =====
// Datapath: control point window, forward difference engine, scalers and output register.
module cbsg_dp #(
    parameter int COORD_BITS     = 16,
    parameter int MAX_STEPS_LOG2 = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cbsg_pkg::cmd_t               cmd,
    output cbsg_pkg::status_t            status,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] start_x,
    output logic signed [COORD_BITS-1:0] start_y,
    output logic signed [COORD_BITS-1:0] end_x,
    output logic signed [COORD_BITS-1:0] end_y,
    output logic                         last_of_span
);

    localparam int C  = COORD_BITS;
    localparam int CW = COORD_BITS + 4;
    localparam int SW = COORD_BITS + 3 * MAX_STEPS_LOG2 + 7;

    // Lane 0 carries x, lane 1 carries y.
    logic signed [C-1:0]  pt_in [2];
    logic signed [C-1:0]  win_reg [2][3];
    logic signed [C-1:0]  p3_reg [2];
    logic signed [CW-1:0] ca_reg [2];
    logic signed [CW-1:0] cb_reg [2];
    logic signed [CW-1:0] cc_reg [2];
    logic signed [CW-1:0] cd_reg [2];
    logic signed [CW-1:0] ca_next [2];
    logic signed [CW-1:0] cb_next [2];
    logic signed [CW-1:0] cc_next [2];
    logic signed [CW-1:0] cd_next [2];
    logic signed [SW-1:0] s_reg [2];
    logic signed [SW-1:0] d1_reg [2];
    logic signed [SW-1:0] d2_reg [2];
    logic signed [SW-1:0] d3_reg [2];
    logic signed [SW-1:0] s_init [2];
    logic signed [SW-1:0] d1_init [2];
    logic signed [SW-1:0] d2_init [2];
    logic signed [SW-1:0] d3_init [2];
    logic signed [C-1:0]  q [2];
    logic signed [C-1:0]  prev_reg [2];
    logic signed [C-1:0]  start_reg [2];
    logic signed [C-1:0]  end_reg [2];

    logic       adv;
    logic       v1_reg;
    logic       f1_reg;
    logic       l1_reg;
    logic       v2_reg;
    logic       f2_reg;
    logic       l2_reg;
    logic       out_valid_reg;
    logic       last_reg;
    logic [3:0] sh2;
    logic [4:0] sh3;

    assign pt_in[0] = in_x;
    assign pt_in[1] = in_y;

    // The whole pipeline moves unless a result waits for the sink.
    assign adv = !out_valid_reg || out_ready;
    assign status.advance = adv;
    assign status.busy    = v1_reg || v2_reg;

    // Polynomial coefficients of the span, in powers of u.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            ca_next[l] = (CW'(p3_reg[l]) - CW'(win_reg[l][0]))
                       + ((CW'(win_reg[l][1]) <<< 1) + CW'(win_reg[l][1]))
                       - ((CW'(win_reg[l][2]) <<< 1) + CW'(win_reg[l][2]));
            cb_next[l] = ((CW'(win_reg[l][0]) <<< 1) + CW'(win_reg[l][0]))
                       - ((CW'(win_reg[l][1]) <<< 2) + (CW'(win_reg[l][1]) <<< 1))
                       + ((CW'(win_reg[l][2]) <<< 1) + CW'(win_reg[l][2]));
            cc_next[l] = ((CW'(win_reg[l][2]) <<< 1) + CW'(win_reg[l][2]))
                       - ((CW'(win_reg[l][0]) <<< 1) + CW'(win_reg[l][0]));
            cd_next[l] = CW'(win_reg[l][0]) + (CW'(win_reg[l][1]) <<< 2)
                       + CW'(win_reg[l][2]);
        end
    end

    // Starting sum and forward differences; powers of N are shifts.
    assign sh2 = {cmd.steps, 1'b0};
    assign sh3 = {1'b0, cmd.steps, 1'b0} + {2'b00, cmd.steps};

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            s_init[l]  = SW'(cd_reg[l]) <<< sh3;
            d1_init[l] = SW'(ca_reg[l]) + (SW'(cb_reg[l]) <<< cmd.steps)
                       + (SW'(cc_reg[l]) <<< sh2);
            d3_init[l] = (SW'(ca_reg[l]) <<< 2) + (SW'(ca_reg[l]) <<< 1);
            d2_init[l] = d3_init[l] + (SW'(cb_reg[l]) <<< (cmd.steps + 3'd1));
        end
    end

    // Window, coefficients and difference engine.
    always_ff @(posedge aclk) begin
        for (int l = 0; l < 2; l++) begin
            if (cmd.store) begin
                win_reg[l][cmd.store_idx] <= pt_in[l];
            end
            if (cmd.load) begin
                p3_reg[l] <= pt_in[l];
            end
            if (cmd.coef) begin
                ca_reg[l]     <= ca_next[l];
                cb_reg[l]     <= cb_next[l];
                cc_reg[l]     <= cc_next[l];
                cd_reg[l]     <= cd_next[l];
                win_reg[l][0] <= win_reg[l][1];
                win_reg[l][1] <= win_reg[l][2];
                win_reg[l][2] <= p3_reg[l];
            end
            if (cmd.init) begin
                s_reg[l]  <= s_init[l];
                d1_reg[l] <= d1_init[l];
                d2_reg[l] <= d2_init[l];
                d3_reg[l] <= d3_init[l];
            end else if (cmd.issue) begin
                s_reg[l]  <= s_reg[l] + d1_reg[l];
                d1_reg[l] <= d1_reg[l] + d2_reg[l];
                d2_reg[l] <= d2_reg[l] + d3_reg[l];
            end
        end
    end

    // One scaler per coordinate lane.
    for (genvar l = 0; l < 2; l++) begin : g_lane
        cbsg_scale #(
            .COORD_BITS     (COORD_BITS),
            .MAX_STEPS_LOG2 (MAX_STEPS_LOG2)
        ) u_scale (
            .aclk   (aclk),
            .en     (adv),
            .steps  (cmd.steps),
            .sum_in (s_reg[l]),
            .q_out  (q[l])
        );
    end

    // Valid bits of the scaler stages and of the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg && !f2_reg;
        end
    end

    // Tags and segment payload; the point at u = 0 only seeds the start.
    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_reg <= cmd.issue_first;
            l1_reg <= cmd.issue_last;
            f2_reg <= f1_reg;
            l2_reg <= l1_reg;
            if (v2_reg) begin
                for (int l = 0; l < 2; l++) begin
                    prev_reg[l] <= q[l];
                    if (!f2_reg) begin
                        start_reg[l] <= prev_reg[l];
                        end_reg[l]   <= q[l];
                    end
                end
                if (!f2_reg) begin
                    last_reg <= l2_reg;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign start_x      = start_reg[0];
    assign start_y      = start_reg[1];
    assign end_x        = end_reg[0];
    assign end_y        = end_reg[1];
    assign last_of_span = last_reg;

endmodule

// ===== design/cbsg_ctrl.sv =====
// Controller: window fill count, span sequencing and the configuration register.
module cbsg_ctrl #(
    parameter int MAX_STEPS_LOG2 = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_first,
    output logic                             s_tready,
    input  logic                             cfg_valid,
    input  logic [cbsg_pkg::STEPS_W-1:0]     cfg_data,
    output logic                             cfg_ready,
    input  cbsg_pkg::status_t                status,
    output cbsg_pkg::cmd_t                   cmd
);

    localparam int KW = MAX_STEPS_LOG2 + 1;
    localparam logic [cbsg_pkg::STEPS_W-1:0] MAX_S = cbsg_pkg::STEPS_W'(MAX_STEPS_LOG2);

    cbsg_pkg::state_t             state_reg;
    cbsg_pkg::state_t             state_next;
    logic [1:0]                   held_reg;
    logic [1:0]                   held_next;
    logic [1:0]                   held_eff;
    logic [KW-1:0]                k_reg;
    logic [KW-1:0]                k_next;
    logic [KW-1:0]                n_val;
    logic [cbsg_pkg::STEPS_W-1:0] steps_log2_reg;
    logic [cbsg_pkg::STEPS_W-1:0] span_steps_reg;
    logic [cbsg_pkg::STEPS_W-1:0] span_steps_next;

    assign cfg_ready = 1'b1;
    assign n_val     = KW'(1) << span_steps_reg;
    assign held_eff  = s_first ? 2'd0 : held_reg;

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cbsg_pkg::ST_IDLE;
            held_reg       <= 2'd0;
            k_reg          <= '0;
            span_steps_reg <= '0;
            steps_log2_reg <= cbsg_pkg::STEPS_RESET;
        end else begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            k_reg          <= k_next;
            span_steps_reg <= span_steps_next;
            if (cfg_valid) begin
                steps_log2_reg <= cfg_data;
            end
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next      = state_reg;
        held_next       = held_reg;
        k_next          = k_reg;
        span_steps_next = span_steps_reg;
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.steps       = span_steps_reg;
        cmd.store_idx   = held_eff;
        case (state_reg)
            cbsg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (held_eff != cbsg_pkg::WINDOW_FULL) begin
                        // Still filling the window: store and produce nothing.
                        cmd.store = 1'b1;
                        held_next = held_eff + 2'd1;
                    end else begin
                        cmd.load        = 1'b1;
                        span_steps_next = (steps_log2_reg > MAX_S) ? MAX_S : steps_log2_reg;
                        state_next      = cbsg_pkg::ST_COEF;
                    end
                end
            end
            cbsg_pkg::ST_COEF: begin
                cmd.coef   = 1'b1;
                state_next = cbsg_pkg::ST_INIT;
            end
            cbsg_pkg::ST_INIT: begin
                cmd.init   = 1'b1;
                k_next     = '0;
                state_next = cbsg_pkg::ST_RUN;
            end
            cbsg_pkg::ST_RUN: begin
                // One curve point per cycle that the pipeline moves.
                if (status.advance) begin
                    cmd.issue       = 1'b1;
                    cmd.issue_first = (k_reg == '0);
                    cmd.issue_last  = (k_reg == n_val);
                    if (k_reg == n_val) begin
                        state_next = cbsg_pkg::ST_DRAIN;
                    end else begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            cbsg_pkg::ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = cbsg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cbsg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/cubic_bspline_segment_generator.sv =====
// Uniform cubic B-spline segment generator: top level with stream ports.
//
// Control points arrive one per transfer; the block keeps the last three of the
// current curve (tuser high starts a new curve). A point that only fills the window
// yields nothing. Every later point closes one span, which is sampled at
// u = k/2^s (s = steps_log2, saturated to MAX_STEPS_LOG2) and sent as 2^s segments,
// tlast on the one that ends at u = 1. Such a point keeps the input closed until its
// span is done: a cubic forward difference engine produces one curve point per cycle
// while the result side does not stall, and a two-stage scaler per coordinate
// divides by 6*2^(3s) with truncation toward zero. The input opens again in the
// cycle after the last segment of a span reaches the output register.
// Configuration writes on cfg_* change steps_log2 (reset 6) and should only be
// made while no span is in progress.
module cubic_bspline_segment_generator #(
    parameter int COORD_BITS     = 16,
    parameter int MAX_STEPS_LOG2 = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel: steps_log2.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbsg_pkg::STEPS_W-1:0]        cfg_data,
    // Control point input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // From bit 0: point_x, point_y, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // Bit 0: first_of_curve.
    input  logic                                s_tuser,
    // Segment output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // From bit 0: start_x, start_y, end_x, end_y, zero fill.
    output logic [((4*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    // last_of_span.
    output logic                                m_tlast
);

    localparam int C        = COORD_BITS;
    localparam int M_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;

    cbsg_pkg::cmd_t       dp_cmd;
    cbsg_pkg::status_t    dp_status;
    logic signed [C-1:0]  start_x;
    logic signed [C-1:0]  start_y;
    logic signed [C-1:0]  end_x;
    logic signed [C-1:0]  end_y;

    // Sequencing.
    cbsg_ctrl #(
        .MAX_STEPS_LOG2 (MAX_STEPS_LOG2)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_first   (s_tuser),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // Arithmetic and result register.
    cbsg_dp #(
        .COORD_BITS     (COORD_BITS),
        .MAX_STEPS_LOG2 (MAX_STEPS_LOG2)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .in_x         ($signed(s_tdata[C-1:0])),
        .in_y         ($signed(s_tdata[2*C-1:C])),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .last_of_span (m_tlast)
    );

    // Pack the segment, first field in the lowest bits.
    assign m_tdata = M_DATA_W'({end_y, end_x, start_y, start_x});

`ifndef SYNTHESIS
    // The input is open only when no curve point is left in the scalers.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dp_status.busy)
        else $error("input ready while scaler stages hold data");

    // A curve point is issued only in a cycle in which the pipeline moves.
    a_issue_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.issue |-> dp_status.advance)
        else $error("curve point issued into a stalled pipeline");

    // An accepted point finds the scalers empty: only a stalled result remains.
    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (m_tvalid == $past(m_tvalid && !m_tready)))
        else $error("result appeared without a span in progress");
`endif

endmodule
